// ===== hdl/frmc_pkg.sv =====
// frmc_pkg: shared types, constants and the value saturation function
// for the first-match range classifier; used by every file in hdl
// depends on nothing
package frmc_pkg;

   localparam int NUM_RULES   = 16;
   localparam int VALUE_WIDTH = 24;
   localparam int NUM_FIELDS  = 6;
   localparam int IN_W        = 24;
   localparam int EXT_W       = (VALUE_WIDTH > IN_W) ? VALUE_WIDTH : IN_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int COUNT_W     = 5;

   typedef logic signed [VALUE_WIDTH-1:0] val_type;
   typedef val_type obs_type [NUM_FIELDS];

   localparam val_type VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam val_type VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // -9900.00 in hundredths
   localparam logic signed [IN_W-1:0] FLOOR_RESET = -24'sd990000;

   typedef enum logic [1:0] {
      REQ_CLASSIFY = 2'd0,
      REQ_WR_LOWER = 2'd1,
      REQ_WR_UPPER = 2'd2,
      REQ_WR_MASK  = 2'd3
   } req_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACTIVE_COUNT  = 2'd0,
      CSR_MISSING_FLOOR = 2'd1
   } csr_index_type;

   typedef struct packed {
      req_code_type            req_type;
      logic [3:0]              rule_index;
      logic [2:0]              field_select;
      logic signed [IN_W-1:0]  limit_value;
      logic [5:0]              enable_mask;
      logic [7:0]              color_in;
      logic signed [IN_W-1:0]  visibility;
      logic signed [IN_W-1:0]  ceiling;
      logic signed [IN_W-1:0]  temperature;
      logic signed [IN_W-1:0]  humidity;
      logic signed [IN_W-1:0]  runway_range;
      logic signed [IN_W-1:0]  wind_speed;
   } req_item_type;

   typedef struct packed {
      logic       pass;
      logic [3:0] matched_rule;
      logic [7:0] color_code;
   } rsp_item_type;

   // table update broadcast to every lane
   typedef struct packed {
      req_code_type code;
      logic [2:0]   field_select;
      val_type      limit;
      logic [5:0]   mask;
      logic [7:0]   color;
   } lane_cmd_type;

   typedef struct packed {
      logic       found;
      logic [3:0] rule_index;
      logic [7:0] color;
   } merge_out_type;

   // sign-extend a 24-bit field and clamp it to the value range
   function automatic val_type sat_value(input logic signed [IN_W-1:0] raw);
      logic signed [EXT_W-1:0] ext;
      logic signed [EXT_W-1:0] vmax;
      logic signed [EXT_W-1:0] vmin;
      ext  = EXT_W'(raw);
      vmax = EXT_W'(VAL_MAX);
      vmin = EXT_W'(VAL_MIN);
      if (ext > vmax) begin
         ext = vmax;
      end else if (ext < vmin) begin
         ext = vmin;
      end
      return val_type'(ext);
   endfunction

endpackage

// ===== hdl/first_match_range_classifier.sv =====
// first_match_range_classifier: top level, request staging, lane array,
// merge and result register
// depends on frmc_pkg, frmc_lane, frmc_merge
//
// each request is taken into a stage register, where every rule lane checks
// the six observation values against its limits in parallel and the merge
// picks the first active hit; table writes are applied from the same stage
// so they stay in order with classify requests. one request per cycle is
// sustained while the receiver keeps up. a request moves from the stage
// register, where the lane checks and the priority pick settle, to the
// result register, which holds the result until it is taken; a request
// waits in the stage while that is blocked. the result register parts
// the two sides, so a new request is taken while a result waits; once a
// result waits and the stage also holds a request, the request side stalls
// until the result is taken. rule limits live in per-lane flip-flops and
// need no clearing pass after reset. csr writes must happen while idle.
module first_match_range_classifier
   import frmc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_item_type           req_payload,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_item_type           rsp_payload,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // stage register contents
   logic         stage_valid_ff, stage_valid_in;
   req_code_type stage_code_ff, stage_code_in;
   logic [3:0]   stage_rule_ff, stage_rule_in;
   lane_cmd_type stage_cmd_ff, stage_cmd_in;
   obs_type      stage_obs_ff, stage_obs_in;

   // result register and kept color
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic [7:0]   last_color_ff, last_color_in;

   // config registers
   logic [COUNT_W-1:0] active_count_ff, active_count_in;
   val_type            floor_ff, floor_in;

   logic                 move;
   logic                 accept;
   logic [NUM_RULES-1:0] lane_wr;
   logic [NUM_RULES-1:0] lane_hit;
   logic [NUM_RULES-1:0] active_hit;
   logic [7:0]           lane_color [NUM_RULES];
   merge_out_type        merged;
   logic                 found;

   // stage hands over when the result register is free or draining
   assign move      = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = stage_valid_ff && !move;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // request staging, values saturated on entry
   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_code_in  = stage_code_ff;
      stage_rule_in  = stage_rule_ff;
      stage_cmd_in   = stage_cmd_ff;
      stage_obs_in   = stage_obs_ff;
      if (accept) begin
         stage_valid_in            = 1'b1;
         stage_code_in             = req_payload.req_type;
         stage_rule_in             = req_payload.rule_index;
         stage_cmd_in.code         = req_payload.req_type;
         stage_cmd_in.field_select = req_payload.field_select;
         stage_cmd_in.limit        = sat_value(req_payload.limit_value);
         stage_cmd_in.mask         = req_payload.enable_mask;
         stage_cmd_in.color        = req_payload.color_in;
         stage_obs_in[0]           = sat_value(req_payload.visibility);
         stage_obs_in[1]           = sat_value(req_payload.ceiling);
         stage_obs_in[2]           = sat_value(req_payload.temperature);
         stage_obs_in[3]           = sat_value(req_payload.humidity);
         stage_obs_in[4]           = sat_value(req_payload.runway_range);
         stage_obs_in[5]           = sat_value(req_payload.wind_speed);
      end else if (move) begin
         stage_valid_in = 1'b0;
      end
   end

   // write strobes: out-of-range rule index matches no lane
   always_comb begin
      for (int r = 0; r < NUM_RULES; r++) begin
         lane_wr[r] = move && (stage_code_ff != REQ_CLASSIFY) &&
                      (32'(stage_rule_ff) == 32'(r));
         // count above the table size naturally enables every lane
         active_hit[r] = lane_hit[r] && (32'(r) < 32'(active_count_ff));
      end
   end

   genvar g;
   generate
      for (g = 0; g < NUM_RULES; g++) begin : g_lane
         frmc_lane u_lane (
            .clock       (clock),
            .reset       (reset),
            .wr_en       (lane_wr[g]),
            .cmd         (stage_cmd_ff),
            .obs         (stage_obs_ff),
            .floor_value (floor_ff),
            .hit         (lane_hit[g]),
            .color       (lane_color[g])
         );
      end
   endgenerate

   frmc_merge u_merge (
      .hits   (active_hit),
      .colors (lane_color),
      .result (merged)
   );

   assign found = merged.found && (stage_code_ff == REQ_CLASSIFY);

   // result register, color held on miss and on writes
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_item_in   = rsp_item_ff;
      last_color_in = last_color_ff;
      if (move) begin
         rsp_valid_in             = 1'b1;
         rsp_item_in.pass         = found;
         rsp_item_in.matched_rule = found ? merged.rule_index : 4'd0;
         rsp_item_in.color_code   = found ? merged.color : last_color_ff;
         last_color_in            = found ? merged.color : last_color_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // register writes
   always_comb begin
      active_count_in = active_count_ff;
      floor_in        = floor_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACTIVE_COUNT: begin
               active_count_in = csr_data[COUNT_W-1:0];
            end
            CSR_MISSING_FLOOR: begin
               floor_in = sat_value(csr_data[IN_W-1:0]);
            end
            default: begin
               active_count_in = active_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         last_color_ff   <= '0;
         active_count_ff <= '0;
         floor_ff        <= sat_value(FLOOR_RESET);
      end else begin
         stage_valid_ff  <= stage_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         last_color_ff   <= last_color_in;
         active_count_ff <= active_count_in;
         floor_ff        <= floor_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      stage_code_ff <= stage_code_in;
      stage_rule_ff <= stage_rule_in;
      stage_cmd_ff  <= stage_cmd_in;
      stage_obs_ff  <= stage_obs_in;
      rsp_item_ff   <= rsp_item_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

   // a waiting result always carries the kept color
   a_color_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.color_code == last_color_ff))
      else $error("result color differs from kept color");

   // a miss reports rule zero
   a_miss_rule_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.pass) |-> (rsp_item_ff.matched_rule == 4'd0))
      else $error("miss reports nonzero rule");

   // request stall only while a staged request cannot move on
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (stage_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a blocked stage");

   // the kept color changes only when a request completes
   a_color_update: assert property (@(posedge clock) disable iff (reset)
      !move |=> $stable(last_color_ff))
      else $error("kept color changed without a completed request");

endmodule

// ===== hdl/frmc_lane.sv =====
// frmc_lane: one rule of the table, its limits, enables and color,
// and the six-field range check against the current observation
// depends on frmc_pkg
module frmc_lane
   import frmc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  lane_cmd_type cmd,
   input  obs_type      obs,
   input  val_type      floor_value,
   output logic         hit,
   output logic [7:0]   color
);

   val_type    lower_ff [NUM_FIELDS];
   val_type    lower_in [NUM_FIELDS];
   val_type    upper_ff [NUM_FIELDS];
   val_type    upper_in [NUM_FIELDS];
   logic [5:0] enables_ff, enables_in;
   logic [7:0] color_ff, color_in;
   logic [NUM_FIELDS-1:0] field_ok;

   always_comb begin
      lower_in   = lower_ff;
      upper_in   = upper_ff;
      enables_in = enables_ff;
      color_in   = color_ff;
      if (wr_en) begin
         if (cmd.code == REQ_WR_MASK) begin
            enables_in = cmd.mask;
            color_in   = cmd.color;
         end else begin
            for (int f = 0; f < NUM_FIELDS; f++) begin
               if (cmd.field_select == 3'(f)) begin
                  if (cmd.code == REQ_WR_LOWER) begin
                     lower_in[f] = cmd.limit;
                  end else if (cmd.code == REQ_WR_UPPER) begin
                     upper_in[f] = cmd.limit;
                  end
                  enables_in[f] = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < NUM_FIELDS; f++) begin
            lower_ff[f] <= VAL_MIN;
            upper_ff[f] <= VAL_MAX;
         end
         enables_ff <= '0;
         color_ff   <= '0;
      end else begin
         lower_ff   <= lower_in;
         upper_ff   <= upper_in;
         enables_ff <= enables_in;
         color_ff   <= color_in;
      end
   end

   // disabled field always passes
   always_comb begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
         field_ok[f] = !enables_ff[f] ||
                       ((obs[f] >= floor_value) && (obs[f] >= lower_ff[f]) &&
                        (obs[f] <= upper_ff[f]));
      end
   end

   assign hit   = &field_ok;
   assign color = color_ff;

endmodule

// ===== hdl/frmc_merge.sv =====
// frmc_merge: priority pick of the lowest hitting lane and its color
// depends on frmc_pkg
module frmc_merge
   import frmc_pkg::*;
(
   input  logic [NUM_RULES-1:0] hits,
   input  logic [7:0]           colors [NUM_RULES],
   output merge_out_type        result
);

   always_comb begin
      result = '0;
      for (int r = NUM_RULES - 1; r >= 0; r--) begin
         if (hits[r]) begin
            result.found      = 1'b1;
            result.rule_index = 4'(r);
            result.color      = colors[r];
         end
      end
   end

endmodule
